// ===== rtl/core/rpam_pkg.sv =====
// Shared constants, register codes and geometry type for the rotation address map.
`default_nettype none

package rpam_pkg;

    localparam int COORD_BITS     = 16;
    localparam int PIXEL_BITS     = 24;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_BITS      = 16;

    localparam int NUM_REGS   = 4;
    localparam int APB_ADDR_W = $clog2(4 * NUM_REGS);
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam int IN_FIELDS_W  = 2 * COORD_BITS + PIXEL_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_BITS + PIXEL_BITS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // signed centre, mirrored offset, products, sums and rounded values
    localparam int CTR_W       = COORD_BITS + 1;
    localparam int OFS_W       = COORD_BITS + 2;
    localparam int SIZE_PROD_W = COORD_BITS + 1 + TRIG_BITS;
    localparam int SIZE_SUM_W  = SIZE_PROD_W + 2;
    localparam int MAP_PROD_W  = OFS_W + TRIG_BITS;
    localparam int MAP_SUM_W   = MAP_PROD_W + 1;
    localparam int RND_W       = MAP_SUM_W + 1 - TRIG_FRAC_BITS;
    localparam int DST_W       = RND_W + 2;

    // cycles the derived geometry needs after a register write
    localparam int CFG_SETTLE = 3;
    localparam int SETTLE_W   = $clog2(CFG_SETTLE + 1);

    localparam logic [COORD_BITS-1:0] RST_SRC_WIDTH  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] RST_SRC_HEIGHT = COORD_BITS'(480);
    localparam logic [TRIG_BITS-1:0]  RST_COSINE     = TRIG_BITS'(16384);
    localparam logic [TRIG_BITS-1:0]  RST_SINE       = TRIG_BITS'(0);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SRC_WIDTH  = REG_IDX_W'(0),
        REG_SRC_HEIGHT = REG_IDX_W'(1),
        REG_COSINE     = REG_IDX_W'(2),
        REG_SINE       = REG_IDX_W'(3)
    } rpam_reg_t;

    typedef struct packed {
        logic signed [TRIG_BITS-1:0]  cosine;
        logic signed [TRIG_BITS-1:0]  sine;
        logic [COORD_BITS-1:0]        width;
        logic [COORD_BITS-1:0]        height;
        logic signed [CTR_W-1:0]      cx;
        logic signed [CTR_W-1:0]      cy;
        logic [COORD_BITS-1:0]        nw;
        logic [COORD_BITS-1:0]        nh;
    } rpam_geom_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpam_cfg.sv =====
// Configuration registers and the derived output size and centres.
`default_nettype none

module rpam_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rpam_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [rpam_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [rpam_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output rpam_pkg::rpam_geom_t                  geom,
    output logic                                  cfg_settled
);

    localparam int CB  = rpam_pkg::COORD_BITS;
    localparam int TB  = rpam_pkg::TRIG_BITS;
    localparam int F   = rpam_pkg::TRIG_FRAC_BITS;
    localparam int SPW = rpam_pkg::SIZE_PROD_W;
    localparam int SSW = rpam_pkg::SIZE_SUM_W;
    localparam int DW  = rpam_pkg::APB_DATA_W;
    localparam logic [SSW-1:0] ROUND_PLUS_ONE = SSW'(3) << (F - 1);
    localparam logic [SSW-F-1:0] SIZE_MAX = (SSW-F)'((64'd1 << CB) - 64'd1);

    logic [CB-1:0]        width_reg, height_reg;
    logic signed [TB-1:0] cos_reg, sin_reg;
    logic [rpam_pkg::SETTLE_W-1:0] settle_reg;
    logic                 wr_en;
    rpam_pkg::rpam_reg_t  wr_idx;

    logic signed [SPW-1:0] wc_reg, hs_reg, hc_reg, ws_reg;
    logic signed [rpam_pkg::CTR_W-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [SSW-1:0] sw_reg, sh_reg;
    logic [CB-1:0]  nw_reg, nh_reg;
    logic [SSW-F-1:0] qw, qh;

    function automatic logic [SSW-1:0] mag(input logic signed [SPW-1:0] p);
        logic [SPW-1:0] m;
        m = p[SPW-1] ? (~p + SPW'(1)) : p;
        return SSW'(m);
    endfunction

    function automatic logic [CB-1:0] sat(input logic [SSW-F-1:0] q);
        return (q > SIZE_MAX) ? SIZE_MAX[CB-1:0] : q[CB-1:0];
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = rpam_pkg::rpam_reg_t'(paddr[rpam_pkg::APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rpam_pkg::RST_SRC_WIDTH;
            height_reg <= rpam_pkg::RST_SRC_HEIGHT;
            cos_reg    <= rpam_pkg::RST_COSINE;
            sin_reg    <= rpam_pkg::RST_SINE;
            settle_reg <= rpam_pkg::SETTLE_W'(rpam_pkg::CFG_SETTLE);
        end else begin
            if (wr_en) begin
                settle_reg <= rpam_pkg::SETTLE_W'(rpam_pkg::CFG_SETTLE);
                unique case (wr_idx)
                    rpam_pkg::REG_SRC_WIDTH:  width_reg  <= pwdata[CB-1:0];
                    rpam_pkg::REG_SRC_HEIGHT: height_reg <= pwdata[CB-1:0];
                    rpam_pkg::REG_COSINE:     cos_reg    <= pwdata[TB-1:0];
                    rpam_pkg::REG_SINE:       sin_reg    <= pwdata[TB-1:0];
                    default: ;
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - rpam_pkg::SETTLE_W'(1);
            end
        end
    end

    assign cfg_settled = (settle_reg == '0);

    always_comb begin
        unique case (wr_idx)
            rpam_pkg::REG_SRC_WIDTH:  prdata = DW'(width_reg);
            rpam_pkg::REG_SRC_HEIGHT: prdata = DW'(height_reg);
            rpam_pkg::REG_COSINE:     prdata = {{(DW-TB){cos_reg[TB-1]}}, cos_reg};
            rpam_pkg::REG_SINE:       prdata = {{(DW-TB){sin_reg[TB-1]}}, sin_reg};
            default:                  prdata = '0;
        endcase
    end

    // source centre: (n + 1) / 2 - 1
    always_comb begin
        logic [CB:0] w1, h1;
        w1 = {1'b0, width_reg} + (CB+1)'(1);
        h1 = {1'b0, height_reg} + (CB+1)'(1);
        cx_next = $signed({1'b0, w1[CB:1]}) - rpam_pkg::CTR_W'(1);
        cy_next = $signed({1'b0, h1[CB:1]}) - rpam_pkg::CTR_W'(1);
    end

    // size products, then magnitude sums, then round, add one and saturate
    always_ff @(posedge aclk) begin
        wc_reg <= $signed({1'b0, width_reg})  * cos_reg;
        hs_reg <= $signed({1'b0, height_reg}) * sin_reg;
        hc_reg <= $signed({1'b0, height_reg}) * cos_reg;
        ws_reg <= $signed({1'b0, width_reg})  * sin_reg;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        sw_reg <= mag(wc_reg) + mag(hs_reg);
        sh_reg <= mag(hc_reg) + mag(ws_reg);
        nw_reg <= sat(qw);
        nh_reg <= sat(qh);
    end

    always_comb begin
        logic [SSW-1:0] tw, th;
        tw = sw_reg + ROUND_PLUS_ONE;
        th = sh_reg + ROUND_PLUS_ONE;
        qw = tw[SSW-1:F];
        qh = th[SSW-1:F];
    end

    assign geom.cosine = cos_reg;
    assign geom.sine   = sin_reg;
    assign geom.width  = width_reg;
    assign geom.height = height_reg;
    assign geom.cx     = cx_reg;
    assign geom.cy     = cy_reg;
    assign geom.nw     = nw_reg;
    assign geom.nh     = nh_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rpam_map.sv =====
// Six-stage coordinate pipeline: mirror, rotate, round, place and bound check.
`default_nettype none

module rpam_map (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  rpam_pkg::rpam_geom_t                    geom,
    input  wire logic                               cfg_settled,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rpam_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [rpam_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                    m_tuser
);

    localparam int CB  = rpam_pkg::COORD_BITS;
    localparam int PB  = rpam_pkg::PIXEL_BITS;
    localparam int F   = rpam_pkg::TRIG_FRAC_BITS;
    localparam int OW  = rpam_pkg::OFS_W;
    localparam int MPW = rpam_pkg::MAP_PROD_W;
    localparam int MSW = rpam_pkg::MAP_SUM_W;
    localparam int DW  = rpam_pkg::DST_W;
    localparam logic [MSW:0] HALF = (MSW+1)'(1) << (F - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic load1, load2, load3, load4, load5, load6;

    logic [PB-1:0] pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg, pix6_reg;
    logic signed [OW-1:0]  x1_reg, y1_reg, x1_next, y1_next;
    logic signed [MPW-1:0] xc2_reg, ys2_reg, xs2_reg, yc2_reg;
    logic signed [MSW-1:0] u3_reg, v3d_reg;
    logic [MSW-1:0]        um4_reg, vm4_reg;
    logic                  un4_reg, vn4_reg;
    logic signed [DW-1:0]  ru5_reg, rv5_reg, ru5_next, rv5_next;
    logic [CB-1:0]         dcol6_reg, drow6_reg, dcol6_next, drow6_next;
    logic                  ok6_reg, ok6_next;

    // a stage takes new data when empty or when its contents move on
    assign load6 = !v6_reg || m_tready;
    assign load5 = !v5_reg || load6;
    assign load4 = !v4_reg || load5;
    assign load3 = !v3_reg || load4;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;
    assign s_tready = load1 && cfg_settled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (load1) v1_reg <= s_tvalid && s_tready;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
            if (load5) v5_reg <= v4_reg;
            if (load6) v6_reg <= v5_reg;
        end
    end

    // mirror about the source centre: x = w - 1 - col - cx
    always_comb begin
        logic [CB-1:0] col, row;
        col = s_tdata[CB-1:0];
        row = s_tdata[2*CB-1:CB];
        x1_next = $signed({2'b00, geom.width}) - $signed({2'b00, col})
                - $signed({geom.cx[rpam_pkg::CTR_W-1], geom.cx}) - OW'(1);
        y1_next = $signed({2'b00, geom.height}) - $signed({2'b00, row})
                - $signed({geom.cy[rpam_pkg::CTR_W-1], geom.cy}) - OW'(1);
    end

    // round half away from zero, restore sign
    always_comb begin
        logic [MSW:0] tu, tv;
        tu = {1'b0, um4_reg} + HALF;
        tv = {1'b0, vm4_reg} + HALF;
        ru5_next = un4_reg ? -$signed({2'b00, tu[MSW:F]}) : $signed({2'b00, tu[MSW:F]});
        rv5_next = vn4_reg ? -$signed({2'b00, tv[MSW:F]}) : $signed({2'b00, tv[MSW:F]});
    end

    // place about the output centre and check bounds
    always_comb begin
        logic signed [DW-1:0] dx, dy, ncx, ncy;
        logic                 okx, oky;
        ncx = $signed(DW'(geom.nw[CB-1:1]));
        ncy = $signed(DW'(geom.nh[CB-1:1]));
        dx  = ncx - ru5_reg;
        dy  = ncy - rv5_reg;
        okx = !dx[DW-1] && (dx < $signed(DW'(geom.nw)));
        oky = !dy[DW-1] && (dy < $signed(DW'(geom.nh)));
        ok6_next   = okx && oky;
        dcol6_next = ok6_next ? dx[CB-1:0] : '0;
        drow6_next = ok6_next ? dy[CB-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            x1_reg   <= x1_next;
            y1_reg   <= y1_next;
            pix1_reg <= s_tdata[2*CB+PB-1:2*CB];
        end
        if (load2) begin
            xc2_reg  <= x1_reg * geom.cosine;
            ys2_reg  <= y1_reg * geom.sine;
            xs2_reg  <= x1_reg * geom.sine;
            yc2_reg  <= y1_reg * geom.cosine;
            pix2_reg <= pix1_reg;
        end
        if (load3) begin
            u3_reg   <= xc2_reg + ys2_reg;
            v3d_reg  <= yc2_reg - xs2_reg;
            pix3_reg <= pix2_reg;
        end
        if (load4) begin
            um4_reg  <= u3_reg[MSW-1]  ? (~u3_reg + MSW'(1))  : u3_reg;
            vm4_reg  <= v3d_reg[MSW-1] ? (~v3d_reg + MSW'(1)) : v3d_reg;
            un4_reg  <= u3_reg[MSW-1];
            vn4_reg  <= v3d_reg[MSW-1];
            pix4_reg <= pix3_reg;
        end
        if (load5) begin
            ru5_reg  <= ru5_next;
            rv5_reg  <= rv5_next;
            pix5_reg <= pix4_reg;
        end
        if (load6) begin
            dcol6_reg <= dcol6_next;
            drow6_reg <= drow6_next;
            ok6_reg   <= ok6_next;
            pix6_reg  <= pix5_reg;
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = rpam_pkg::OUT_TDATA_W'({pix6_reg, drow6_reg, dcol6_reg});
    assign m_tuser  = ok6_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rotate_pixel_address_map_top.sv =====
// Forward address map for nearest-neighbor image rotation: top level.
//
// Source pixels enter on the s_ stream (column, row, pixel value) and each
// one leaves as a single request on the m_ stream with its destination
// column and row in the rotated image, the pixel unchanged, and an
// in-bounds flag in m_tuser; out-of-bounds requests carry zero coordinates.
// The APB port holds source width, source height, cosine and sine (Q1.14).
// Output width and height and both centers are derived from these registers
// in a three-stage chain; s_tready stays low after a write and after reset
// while that chain settles. Throughput is one pixel per clock while the
// output accepts and the geometry has settled. A result is valid once it
// has passed the six register stages of the map pipeline (mirror, multiply,
// sum, magnitude, round, place and check). When m_tready is low, empty
// stages still fill, so up to six pixels are held without loss; s_tready
// falls when every stage is occupied and also while the geometry settles.
// Reset is synchronous, active low: the pipeline empties and the registers
// return to 640 x 480 with no rotation.
`default_nettype none

module rotate_pixel_address_map_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rpam_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [rpam_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [rpam_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // src_col, src_row, pixel_value
    input  wire logic [rpam_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // dest_col, dest_row, pixel_out
    output logic      [rpam_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // in_bounds
    output logic                                    m_tuser
);

    localparam int CB = rpam_pkg::COORD_BITS;

    rpam_pkg::rpam_geom_t geom;
    logic                 cfg_settled;

    rpam_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .geom        (geom),
        .cfg_settled (cfg_settled)
    );

    rpam_map u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .geom        (geom),
        .cfg_settled (cfg_settled),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    a_no_accept_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite) |=> !(s_tvalid && s_tready))
        else $error("pixel accepted while geometry settles");

    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[2*CB-1:0] == '0))
        else $error("out-of-bounds request carries nonzero coordinates");

    a_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            ((m_tdata[CB-1:0] < geom.nw) && (m_tdata[2*CB-1:CB] < geom.nh)))
        else $error("in-bounds request outside output size");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the rotation pixel address map: APB setup, streamed pixels.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;
    localparam int PHASE_PIXELS   = 62;
    localparam int CB             = rpam_pkg::COORD_BITS;
    localparam int PB             = rpam_pkg::PIXEL_BITS;
    localparam int TB             = rpam_pkg::TRIG_BITS;
    localparam int F              = rpam_pkg::TRIG_FRAC_BITS;

    typedef struct packed {
        logic [CB-1:0] dest_col;
        logic [CB-1:0] dest_row;
        logic [PB-1:0] pixel;
        logic          in_bounds;
    } placed_pixel_t;

    typedef struct {
        logic [CB-1:0] col;
        logic [CB-1:0] row;
        logic [PB-1:0] pix;
        bit            typed;
        placed_pixel_t result;
    } pixel_case_t;

    typedef struct {
        logic [CB-1:0]        w;
        logic [CB-1:0]        h;
        logic signed [TB-1:0] cs;
        logic signed [TB-1:0] sn;
    } rot_setting_t;

    logic                                aclk     = 1'b0;
    logic                                aresetn  = 1'b0;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [rpam_pkg::APB_ADDR_W-1:0]     paddr    = '0;
    logic [rpam_pkg::APB_DATA_W-1:0]     pwdata   = '0;
    logic [rpam_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [rpam_pkg::IN_TDATA_W-1:0]     s_tdata  = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [rpam_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                m_tuser;

    // local copy of the register file
    logic [CB-1:0]        cfg_w   = rpam_pkg::RST_SRC_WIDTH;
    logic [CB-1:0]        cfg_h   = rpam_pkg::RST_SRC_HEIGHT;
    logic signed [TB-1:0] cfg_cos = rpam_pkg::RST_COSINE;
    logic signed [TB-1:0] cfg_sin = rpam_pkg::RST_SINE;

    placed_pixel_t placed_q[$];
    int            sent_cnt     = 0;
    int            results_seen = 0;
    int            err_count    = 0;
    int            idle_cycles  = 0;
    int            hold_left    = 0;
    bit            long_hold_done = 1'b0;

    rotate_pixel_address_map_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint round_half_away(longint p);
        longint mag;
        longint r;
        mag = (p < 0) ? -p : p;
        r = (mag + (longint'(1) <<< (F - 1))) >>> F;
        return (p < 0) ? -r : r;
    endfunction

    function automatic longint rotated_size(longint a, longint b);
        longint pa;
        longint pb;
        longint n;
        pa = a * longint'(cfg_cos);
        pb = b * longint'(cfg_sin);
        n = round_half_away(((pa < 0) ? -pa : pa) + ((pb < 0) ? -pb : pb)) + 1;
        if (n > (longint'(1) <<< CB) - 1)
            n = (longint'(1) <<< CB) - 1;
        return n;
    endfunction

    function automatic placed_pixel_t place_pixel(logic [CB-1:0] c,
                                                  logic [CB-1:0] r,
                                                  logic [PB-1:0] p);
        longint w, h, cs, sn, nw, nh, x, y, dx, dy;
        placed_pixel_t res;
        w  = cfg_w;
        h  = cfg_h;
        cs = cfg_cos;
        sn = cfg_sin;
        nw = rotated_size(w, h);
        nh = rotated_size(h, w);
        // mirror about the source center
        x  = w - 1 - longint'(c) - ((w + 1) / 2 - 1);
        y  = h - 1 - longint'(r) - ((h + 1) / 2 - 1);
        dx = nw / 2 - round_half_away(x * cs + y * sn);
        dy = nh / 2 - round_half_away(-x * sn + y * cs);
        res.in_bounds = (dx >= 0 && dx < nw && dy >= 0 && dy < nh);
        res.dest_col  = res.in_bounds ? CB'(dx) : '0;
        res.dest_row  = res.in_bounds ? CB'(dy) : '0;
        res.pixel     = p;
        return res;
    endfunction

    task automatic write_reg(input rpam_pkg::rpam_reg_t idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rpam_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata  <= rpam_pkg::APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rpam_pkg::REG_SRC_WIDTH:  cfg_w   = val;
            rpam_pkg::REG_SRC_HEIGHT: cfg_h   = val;
            rpam_pkg::REG_COSINE:     cfg_cos = val;
            rpam_pkg::REG_SINE:       cfg_sin = val;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [CB-1:0] c, input logic [CB-1:0] r,
                              input logic [PB-1:0] p, input bit typed,
                              input placed_pixel_t typed_res);
        int gap_pct;
        gap_pct = (sent_cnt < 170) ? 32 : (sent_cnt < 340) ? 67 : 0;
        // idle cycle by cycle so the idle share matches gap_pct
        while ($urandom_range(99, 0) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rpam_pkg::IN_TDATA_W'({p, r, c});
        do @(posedge aclk); while (!s_tready);
        placed_q.push_back(typed ? typed_res : place_pixel(c, r, p));
        sent_cnt++;
    endtask

    task automatic send_random_pixel();
        logic [CB-1:0] c;
        logic [CB-1:0] r;
        // mostly coordinates inside the source, the rest anywhere
        if (cfg_w != 0 && cfg_h != 0 && $urandom_range(99, 0) < 85) begin
            c = CB'($urandom_range(int'(cfg_w) - 1, 0));
            r = CB'($urandom_range(int'(cfg_h) - 1, 0));
        end else begin
            c = CB'($urandom);
            r = CB'($urandom);
        end
        send_pixel(c, r, PB'($urandom), 1'b0, '0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (placed_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // receiver: random back-pressure plus one long hold once traffic is flowing
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 120) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_tready       <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >=
                         ((sent_cnt < 170) ? 67 : (sent_cnt < 340) ? 32 : 0));
        end
    end

    function automatic void check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        placed_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (placed_q.size() == 0) begin
                $display("%0t: unexpected request, expected none, got %h/%b",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                want = placed_q.pop_front();
                check_field("dest_col",  want.dest_col,  m_tdata[CB-1:0]);
                check_field("dest_row",  want.dest_row,  m_tdata[2*CB-1:CB]);
                check_field("pixel_out", want.pixel, m_tdata[2*CB+PB-1:2*CB]);
                check_field("in_bounds", want.in_bounds, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    pixel_case_t directed_tbl[10] = '{
        '{16'd0,     16'd0,     24'h000000, 1'b1, '{16'd0,   16'd0,   24'h000000, 1'b1}},
        '{16'd639,   16'd479,   24'hFFFFFF, 1'b1, '{16'd639, 16'd479, 24'hFFFFFF, 1'b1}},
        '{16'd319,   16'd239,   24'hA5A5A5, 1'b1, '{16'd319, 16'd239, 24'hA5A5A5, 1'b1}},
        '{16'hFFFF,  16'hFFFF,  24'h5A5A5A, 1'b1, '{16'd0,   16'd0,   24'h5A5A5A, 1'b0}},
        '{16'd0,     16'hFFFF,  24'h123456, 1'b1, '{16'd0,   16'd0,   24'h123456, 1'b0}},
        '{16'hFFFF,  16'd0,     24'h800001, 1'b1, '{16'd0,   16'd0,   24'h800001, 1'b0}},
        '{16'd640,   16'd480,   24'h7FFFFF, 1'b0, '0},
        '{16'd1,     16'd2,     24'h000001, 1'b0, '0},
        '{16'hAAAA,  16'h5555,  24'hAAAAAA, 1'b0, '0},
        '{16'h5555,  16'hAAAA,  24'h555555, 1'b0, '0}
    };

    rot_setting_t setting_tbl[7] = '{
        '{16'd640,   16'd480,   16'sd0,      16'sd16384},  // quarter turn
        '{16'd1,     16'd1,     -16'sd16384, 16'sd0},      // half turn, single pixel
        '{16'hFFFF,  16'hFFFF,  16'sd11585,  16'sd11585},  // output size saturates
        '{16'd0,     16'd0,     16'sd16384,  16'sd0},      // empty source
        '{16'd300,   16'd200,   16'sh8000,   16'sh7FFF},   // trig beyond unit range
        '{16'hFFFF,  16'd1,     -16'sd11585, -16'sd11585},
        '{16'd37,    16'd53,    16'sd13378,  -16'sd9459}
    };

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_tbl[i])
            send_pixel(directed_tbl[i].col, directed_tbl[i].row, directed_tbl[i].pix,
                       directed_tbl[i].typed, directed_tbl[i].result);

        for (int ph = 0; ph <= 7; ph++) begin
            // reconfigure only once the pipeline has emptied
            drain_results();
            if (ph < 7) begin
                write_reg(rpam_pkg::REG_SRC_WIDTH,  setting_tbl[ph].w);
                write_reg(rpam_pkg::REG_SRC_HEIGHT, setting_tbl[ph].h);
                write_reg(rpam_pkg::REG_COSINE,     setting_tbl[ph].cs);
                write_reg(rpam_pkg::REG_SINE,       setting_tbl[ph].sn);
            end else begin
                write_reg(rpam_pkg::REG_SRC_WIDTH,  16'($urandom_range(2000, 1)));
                write_reg(rpam_pkg::REG_SRC_HEIGHT, 16'($urandom_range(2000, 1)));
                write_reg(rpam_pkg::REG_COSINE,
                          16'(int'($urandom_range(32768, 0)) - 16384));
                write_reg(rpam_pkg::REG_SINE,
                          16'(int'($urandom_range(32768, 0)) - 16384));
            end
            repeat (PHASE_PIXELS) send_random_pixel();
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rpam_pkg.sv
rtl/core/rpam_cfg.sv
rtl/core/rpam_map.sv
rtl/core/rotate_pixel_address_map_top.sv
verif/tb.sv
